// ===== sv/elevator_car_controller_defines.svh =====
// Assertion macros used by the block that checks its own logic.
// Each macro samples on the rising edge of clk and is disabled during reset.
`ifndef ELEVATOR_CAR_CONTROLLER_DEFINES_SVH
`define ELEVATOR_CAR_CONTROLLER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ECC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ECC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ecc_pkg.sv =====
package ecc_pkg;

    // Operation codes of an input beat.
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_CALL  = 3'd1;
    localparam logic [2:0] OP_OPEN  = 3'd2;
    localparam logic [2:0] OP_CLOSE = 3'd3;
    localparam logic [2:0] OP_EMG   = 3'd4;

    // Mode codes as reported on the result channel.
    localparam logic [2:0] MODE_CODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_CODE_UP    = 3'd1;
    localparam logic [2:0] MODE_CODE_DOWN  = 3'd2;
    localparam logic [2:0] MODE_CODE_OPEN  = 3'd3;
    localparam logic [2:0] MODE_CODE_WAIT  = 3'd4;
    localparam logic [2:0] MODE_CODE_CLOSE = 3'd5;
    localparam logic [2:0] MODE_CODE_EMG   = 3'd6;

    // Configuration register map.
    localparam int unsigned APB_ADDR_W = 3;
    localparam logic REG_STEPS_PER_FLOOR = 1'b0;
    localparam logic REG_DOOR_HOLD_MS    = 1'b1;

    localparam logic [15:0] STEPS_PER_FLOOR_RESET = 16'd4096;
    localparam logic [31:0] DOOR_HOLD_MS_RESET    = 32'd10000;
    localparam logic [7:0]  FLOOR_RESET           = 8'd1;

    typedef enum logic [6:0] {
        MODE_IDLE  = 7'b0000001,
        MODE_UP    = 7'b0000010,
        MODE_DOWN  = 7'b0000100,
        MODE_OPEN  = 7'b0001000,
        MODE_WAIT  = 7'b0010000,
        MODE_CLOSE = 7'b0100000,
        MODE_EMG   = 7'b1000000
    } mode_t;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  floor_number;
        logic [31:0] now_ms;
        logic        step_done;
        logic        door_closed;
    } ecc_in_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] floor_now;
        logic       step_request;
        logic       step_upward;
        logic       door_open_cmd;
        logic       door_close_cmd;
    } ecc_out_t;

    function automatic logic [2:0] mode_code(input mode_t m);
        logic [2:0] code;
        unique case (m)
            MODE_IDLE:  code = MODE_CODE_IDLE;
            MODE_UP:    code = MODE_CODE_UP;
            MODE_DOWN:  code = MODE_CODE_DOWN;
            MODE_OPEN:  code = MODE_CODE_OPEN;
            MODE_WAIT:  code = MODE_CODE_WAIT;
            MODE_CLOSE: code = MODE_CODE_CLOSE;
            MODE_EMG:   code = MODE_CODE_EMG;
            default:    code = MODE_CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

// ===== sv/ecc_if.sv =====
// Command channel: one beat per operation.
interface ecc_cmd_if
    import ecc_pkg::*;
;
    logic    valid;
    logic    ready;
    ecc_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Status channel: one beat per accepted operation.
interface ecc_status_if
    import ecc_pkg::*;
;
    logic     valid;
    logic     ready;
    ecc_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/elevator_car_controller.sv =====
// Path: an accepted command beat passes the input register, then the status register.
// Throughput: one command beat per clock cycle while the status side is ready; the
// input register and the status register let a new beat enter while a finished status still waits.
// Reset (rst_n low, asynchronous): car idle at floor 1, target floor 1, step
// count and door timestamp zero, 4096 steps per floor, 10000 ms door hold.
`include "elevator_car_controller_defines.svh"

module elevator_car_controller
    import ecc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    ecc_cmd_if.sink               cmd,
    ecc_status_if.source          status,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    // ------------------------------------------------------------------
    // Configuration registers. Register index is the word address bit;
    // the byte offset bits are ignored.
    // ------------------------------------------------------------------
    logic [15:0] steps_per_floor_reg;
    logic [31:0] door_hold_ms_reg;
    logic        cfg_write;
    logic        cfg_index;

    assign pready    = 1'b1;
    assign cfg_index = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_per_floor_reg <= STEPS_PER_FLOOR_RESET;
            door_hold_ms_reg    <= DOOR_HOLD_MS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_STEPS_PER_FLOOR: steps_per_floor_reg <= pwdata[15:0];
                REG_DOOR_HOLD_MS:    door_hold_ms_reg    <= pwdata;
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            REG_STEPS_PER_FLOOR: prdata = {16'd0, steps_per_floor_reg};
            REG_DOOR_HOLD_MS:    prdata = door_hold_ms_reg;
            default:             prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Two-stage datapath. The input register captures a command beat; once
    // it advances, the controller state and the status register update
    // together from it. Stage one advances whenever the status register is
    // empty or being drained, so a beat can enter on every cycle.
    // ------------------------------------------------------------------
    logic     in_valid_reg;
    ecc_in_t  in_data_reg;
    logic     out_valid_reg;
    ecc_out_t out_data_reg;
    logic     advance;

    assign advance   = in_valid_reg && (!out_valid_reg || status.ready);
    assign cmd.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            in_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            in_data_reg <= cmd.data;
        end
    end

    // ------------------------------------------------------------------
    // Controller state.
    // ------------------------------------------------------------------
    mode_t       mode_reg;
    mode_t       mode_next;
    logic [7:0]  current_floor_reg;
    logic [7:0]  current_floor_next;
    logic [7:0]  target_floor_reg;
    logic [7:0]  target_floor_next;
    logic [15:0] step_count_reg;
    logic [15:0] step_count_next;
    logic [31:0] door_start_ms_reg;
    logic [31:0] door_start_ms_next;
    ecc_out_t    result;

    // Travel helpers: the incremented step count wraps at 16 bits, and the
    // floor moves by one in the direction of travel, wrapping at 8 bits.
    logic [15:0] step_inc;
    logic        floor_done;
    logic        moving_up;
    logic [7:0]  floor_stepped;
    logic [31:0] door_elapsed;

    assign step_inc      = step_count_reg + 16'd1;
    assign floor_done    = (step_inc >= steps_per_floor_reg);
    assign moving_up     = (mode_reg == MODE_UP);
    assign floor_stepped = moving_up ? current_floor_reg + 8'd1
                                     : current_floor_reg - 8'd1;
    assign door_elapsed  = in_data_reg.now_ms - door_start_ms_reg;

    always_comb
    begin
        mode_next             = mode_reg;
        current_floor_next    = current_floor_reg;
        target_floor_next     = target_floor_reg;
        step_count_next       = step_count_reg;
        door_start_ms_next    = door_start_ms_reg;
        result.step_request   = 1'b0;
        result.step_upward    = 1'b0;
        result.door_open_cmd  = 1'b0;
        result.door_close_cmd = 1'b0;

        unique case (in_data_reg.opcode)
            OP_TICK:
            begin
                unique case (mode_reg)
                    MODE_IDLE:
                    begin
                        if (target_floor_reg > current_floor_reg)
                        begin
                            mode_next = MODE_UP;
                        end
                        else if (target_floor_reg < current_floor_reg)
                        begin
                            mode_next = MODE_DOWN;
                        end
                    end
                    MODE_UP, MODE_DOWN:
                    begin
                        // The stepper is driven on every tick while moving.
                        // A target changed mid-travel can be overshot: the
                        // car only stops when the floor equals the target.
                        result.step_request = 1'b1;
                        result.step_upward  = moving_up;
                        if (in_data_reg.step_done)
                        begin
                            if (floor_done)
                            begin
                                step_count_next    = 16'd0;
                                current_floor_next = floor_stepped;
                                if (floor_stepped == target_floor_reg)
                                begin
                                    mode_next = MODE_OPEN;
                                end
                            end
                            else
                            begin
                                step_count_next = step_inc;
                            end
                        end
                    end
                    MODE_OPEN:
                    begin
                        result.door_open_cmd = 1'b1;
                        door_start_ms_next   = in_data_reg.now_ms;
                        mode_next            = MODE_WAIT;
                    end
                    MODE_WAIT:
                    begin
                        if (door_elapsed > door_hold_ms_reg)
                        begin
                            mode_next = MODE_CLOSE;
                        end
                    end
                    MODE_CLOSE:
                    begin
                        result.door_close_cmd = 1'b1;
                        if (in_data_reg.door_closed)
                        begin
                            mode_next = MODE_IDLE;
                        end
                    end
                    default:
                    begin
                        // Emergency hold: the car stays put on ticks.
                    end
                endcase
            end
            OP_CALL:
            begin
                target_floor_next = in_data_reg.floor_number;
                if (in_data_reg.floor_number == current_floor_reg)
                begin
                    mode_next          = MODE_OPEN;
                    door_start_ms_next = in_data_reg.now_ms;
                end
            end
            OP_OPEN:
            begin
                mode_next          = MODE_OPEN;
                door_start_ms_next = in_data_reg.now_ms;
            end
            OP_CLOSE:
            begin
                mode_next = MODE_CLOSE;
            end
            OP_EMG:
            begin
                mode_next = MODE_EMG;
            end
            default:
            begin
                // Unused opcodes leave the state alone.
            end
        endcase

        result.mode      = mode_code(mode_next);
        result.floor_now = current_floor_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_IDLE;
            current_floor_reg <= FLOOR_RESET;
            target_floor_reg  <= FLOOR_RESET;
            step_count_reg    <= 16'd0;
            door_start_ms_reg <= 32'd0;
        end
        else if (advance)
        begin
            mode_reg          <= mode_next;
            current_floor_reg <= current_floor_next;
            target_floor_reg  <= target_floor_next;
            step_count_reg    <= step_count_next;
            door_start_ms_reg <= door_start_ms_next;
        end
    end

    // ------------------------------------------------------------------
    // Status register.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (status.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign status.valid = out_valid_reg;
    assign status.data  = out_data_reg;

    // ------------------------------------------------------------------
    // Checks on the controller's own logic.
    // ------------------------------------------------------------------
    // A driven step is only reported while moving or on arrival at the target.
    `ECC_ASSERT_SAME(a_step_only_moving,
        out_valid_reg && out_data_reg.step_request,
        out_data_reg.mode == MODE_CODE_UP || out_data_reg.mode == MODE_CODE_DOWN ||
        out_data_reg.mode == MODE_CODE_OPEN,
        "step request reported outside travel")
    // The open command always leaves the car in door wait.
    `ECC_ASSERT_SAME(a_open_then_wait,
        out_valid_reg && out_data_reg.door_open_cmd,
        out_data_reg.mode == MODE_CODE_WAIT,
        "door open command without door wait mode")
    // A step direction is never reported without a step.
    `ECC_ASSERT_SAME(a_dir_needs_step,
        out_valid_reg && out_data_reg.step_upward,
        out_data_reg.step_request,
        "step direction without step request")
    // With both stages full and the status side stalled, no beat enters.
    `ECC_ASSERT_SAME(a_full_blocks_input,
        in_valid_reg && out_valid_reg && !status.ready,
        !cmd.ready,
        "command accepted while pipeline is full")
    // A held status beat keeps the controller state frozen.
    `ECC_ASSERT_NEXT(a_stall_freezes_state,
        out_valid_reg && !status.ready,
        $stable(current_floor_reg) && $stable(step_count_reg),
        "state changed while status was stalled")

endmodule
